// ===== design/chs_pkg.sv =====
package chs_pkg;

    typedef enum logic [1:0] {
        FUNC_SEARCH = 2'd0,
        FUNC_ADD    = 2'd1,
        FUNC_FIRST  = 2'd2,
        FUNC_NEXT   = 2'd3
    } func_t;

    localparam int KEY_W  = 32;
    localparam int FUNC_W = 2;
    localparam int TID_W  = 2;

endpackage

// ===== design/chs_entry_mem.sv =====
module chs_entry_mem
    import chs_pkg::*;
#(
    parameter int CAPACITY = 256,
    parameter int IDX_W    = 8
) (
    input  logic                aclk,
    input  logic [IDX_W-1:0]    rd_addr,
    output logic [KEY_W-1:0]    rd_key,
    output logic [IDX_W:0]      rd_chain,
    output logic [IDX_W:0]      rd_order,
    input  logic                wr_key_en,
    input  logic [IDX_W-1:0]    wr_key_addr,
    input  logic [KEY_W-1:0]    wr_key,
    input  logic                wr_chain_en,
    input  logic [IDX_W-1:0]    wr_chain_addr,
    input  logic [IDX_W:0]      wr_chain,
    input  logic                wr_order_en,
    input  logic [IDX_W-1:0]    wr_order_addr,
    input  logic [IDX_W:0]      wr_order
);

    logic [KEY_W-1:0] key_mem   [CAPACITY];
    logic [IDX_W:0]   chain_mem [CAPACITY];
    logic [IDX_W:0]   order_mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (wr_key_en) begin
            key_mem[wr_key_addr] <= wr_key;
        end
        rd_key <= key_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_chain_en) begin
            chain_mem[wr_chain_addr] <= wr_chain;
        end
        rd_chain <= chain_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (wr_order_en) begin
            order_mem[wr_order_addr] <= wr_order;
        end
        rd_order <= order_mem[rd_addr];
    end

endmodule

// ===== design/chained_hash_set_with_ordered_walk.sv =====
// channel | ports                                   | direction
// input   | s_valid s_ready s_func s_table_id s_key | in
// result  | m_valid m_ready m_hit m_stored_key m_pool_full | out
// one item at a time; search and add go through reciprocal multiply, narrow remainder,
// head read and a chain read for each chain entry visited, an add of a new key through
// the insert states; first and next walk the table's insertion order; unknown table goes straight to the result
// after reset a clearing pass over all NUM_TABLES*BUCKETS bucket heads empties them
// before the first transfer is accepted
// a stalled result holds in the output register; the next item waits, and the block
// returns to idle after each result transfer before it accepts the next item
module chained_hash_set_with_ordered_walk
    import chs_pkg::*;
#(
    parameter int NUM_TABLES = 4,
    parameter int BUCKETS    = 64,
    parameter int CAPACITY   = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [FUNC_W-1:0] s_func,
    input  logic [TID_W-1:0]  s_table_id,
    input  logic [KEY_W-1:0]  s_key,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_hit,
    output logic [KEY_W-1:0]  m_stored_key,
    output logic              m_pool_full
);

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int HEADS   = NUM_TABLES * BUCKETS;
    localparam int HIDX_W  = (HEADS > 1) ? $clog2(HEADS) : 1;
    localparam int BIDX_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int TIDX_W  = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
    localparam logic [IDX_W:0] NIL = (IDX_W+1)'(CAPACITY);
    localparam int MOD_SH  = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
    localparam logic [32:0] MOD_MUL =
        33'(((64'd1 << (32 + MOD_SH)) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
    localparam logic [BIDX_W-1:0] BKT_LOW = BIDX_W'(BUCKETS);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_HIDX, S_HEAD, S_HREAD, S_READ, S_CMP, S_INS1, S_INS2,
        S_WALK, S_WNEXT, S_WREAD, S_WKEY, S_OUT
    } state_t;

    state_t state_reg;
    logic [HIDX_W-1:0] clr_reg;
    logic [FUNC_W-1:0] func_reg;
    logic [TID_W-1:0]  tid_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [HIDX_W-1:0] hidx_reg;
    logic [BIDX_W-1:0] quot_reg;
    logic [BIDX_W-1:0] rem;
    logic [IDX_W:0]    cur_reg;
    logic [IDX_W:0]    used_reg;
    logic [IDX_W:0]    last_reg;
    logic [IDX_W:0]    order_head_reg [NUM_TABLES];
    logic [IDX_W:0]    order_tail_reg [NUM_TABLES];
    logic [IDX_W:0]    cursor_reg     [NUM_TABLES];
    logic              hit_reg, full_reg;
    logic [KEY_W-1:0]  sk_reg;

    logic [IDX_W:0] first_mem [HEADS];
    logic [IDX_W:0] last_mem  [HEADS];
    logic [IDX_W:0] first_rd, last_rd;
    logic           hwe;
    logic [HIDX_W-1:0] hw_addr;
    logic [IDX_W:0] hw_first, hw_last;
    logic           hw_first_en;

    logic [IDX_W-1:0] rd_addr;
    logic [KEY_W-1:0] rd_key;
    logic [IDX_W:0]   rd_chain, rd_order;
    logic wk_en, wc_en, wo_en;
    logic [IDX_W-1:0] wc_addr, wo_addr;
    logic [IDX_W:0]   wc_data;
    logic [TIDX_W-1:0] tsel;

    assign tsel = TIDX_W'(tid_reg);
    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign m_hit = hit_reg;
    assign m_stored_key = sk_reg;
    assign m_pool_full = full_reg;

    // remainder only needs the low bits of key - quotient * BUCKETS
    assign rem = key_reg[BIDX_W-1:0] - quot_reg * BKT_LOW;

    always_ff @(posedge aclk) begin
        if (hwe) begin
            if (hw_first_en) begin
                first_mem[hw_addr] <= hw_first;
            end
            last_mem[hw_addr] <= hw_last;
        end
        first_rd <= first_mem[hidx_reg];
        last_rd  <= last_mem[hidx_reg];
    end

    always_comb begin
        hwe = 1'b0;
        hw_first_en = 1'b1;
        hw_addr = hidx_reg;
        hw_first = NIL;
        hw_last = NIL;
        wk_en = 1'b0;
        wc_en = 1'b0;
        wo_en = 1'b0;
        wc_addr = last_reg[IDX_W-1:0];
        wc_data = used_reg;
        wo_addr = order_tail_reg[tsel][IDX_W-1:0];
        rd_addr = cur_reg[IDX_W-1:0];
        if (state_reg == S_CLEAR) begin
            hwe = 1'b1;
            hw_addr = clr_reg;
        end
        if (state_reg == S_INS1) begin
            hwe = 1'b1;
            hw_first_en = (last_rd == NIL);
            hw_first = used_reg;
            hw_last = used_reg;
            wk_en = 1'b1;
            wc_en = 1'b1;
            wc_addr = used_reg[IDX_W-1:0];
            wc_data = NIL;
            wo_en = 1'b1;
            wo_addr = used_reg[IDX_W-1:0];
        end
        if (state_reg == S_INS2) begin
            wc_en = (last_reg != NIL);
            wo_en = (order_tail_reg[tsel] != NIL);
        end
    end

    chs_entry_mem #(.CAPACITY(CAPACITY), .IDX_W(IDX_W)) u_mem (
        .aclk          (aclk),
        .rd_addr       (rd_addr),
        .rd_key        (rd_key),
        .rd_chain      (rd_chain),
        .rd_order      (rd_order),
        .wr_key_en     (wk_en),
        .wr_key_addr   (used_reg[IDX_W-1:0]),
        .wr_key        (key_reg),
        .wr_chain_en   (wc_en),
        .wr_chain_addr (wc_addr),
        .wr_chain      (wc_data),
        .wr_order_en   (wo_en),
        .wr_order_addr (wo_addr),
        .wr_order      (wc_en && state_reg == S_INS1 ? NIL : (state_reg == S_INS1 ? NIL : used_reg))
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            used_reg <= '0;
            for (int i = 0; i < NUM_TABLES; i++) begin
                order_head_reg[i] <= NIL;
                order_tail_reg[i] <= NIL;
                cursor_reg[i] <= NIL;
            end
        end else begin
            unique case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (32'(clr_reg) == HEADS - 1) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        func_reg <= s_func;
                        tid_reg <= s_table_id;
                        key_reg <= s_key;
                        hit_reg <= 1'b0;
                        sk_reg <= '0;
                        full_reg <= 1'b0;
                        if (32'(s_table_id) >= NUM_TABLES) begin
                            state_reg <= S_OUT;
                        end else if (s_func == FUNC_SEARCH || s_func == FUNC_ADD) begin
                            state_reg <= S_HASH;
                        end else begin
                            state_reg <= S_WALK;
                        end
                    end
                end
                S_HASH: begin
                    // quotient by reciprocal multiplication, exact for 32-bit keys
                    quot_reg <= BIDX_W'((65'(key_reg) * 65'(MOD_MUL)) >> (32 + MOD_SH));
                    state_reg <= S_HIDX;
                end
                S_HIDX: begin
                    hidx_reg <= HIDX_W'(32'(tid_reg) * BUCKETS + 32'(rem));
                    state_reg <= S_HEAD;
                end
                S_HEAD: state_reg <= S_HREAD;
                S_HREAD: begin
                    cur_reg <= first_rd;
                    last_reg <= last_rd;
                    state_reg <= S_READ;
                end
                S_READ: begin
                    if (cur_reg == NIL) begin
                        if (func_reg == FUNC_ADD) begin
                            if (used_reg >= (IDX_W+1)'(CAPACITY)) begin
                                full_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end else begin
                                state_reg <= S_INS1;
                            end
                        end else begin
                            state_reg <= S_OUT;
                        end
                    end else begin
                        state_reg <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (rd_key == key_reg) begin
                        hit_reg <= 1'b1;
                        sk_reg <= rd_key;
                        state_reg <= S_OUT;
                    end else begin
                        cur_reg <= rd_chain;
                        state_reg <= S_READ;
                    end
                end
                S_INS1: state_reg <= S_INS2;
                S_INS2: begin
                    if (order_tail_reg[tsel] == NIL) begin
                        order_head_reg[tsel] <= used_reg;
                    end
                    order_tail_reg[tsel] <= used_reg;
                    used_reg <= used_reg + 1'b1;
                    state_reg <= S_OUT;
                end
                S_WALK: begin
                    if (func_reg == FUNC_FIRST) begin
                        cursor_reg[tsel] <= order_head_reg[tsel];
                        cur_reg <= order_head_reg[tsel];
                        state_reg <= (order_head_reg[tsel] == NIL) ? S_OUT : S_WKEY;
                    end else begin
                        cur_reg <= cursor_reg[tsel];
                        state_reg <= (cursor_reg[tsel] == NIL) ? S_OUT : S_WNEXT;
                    end
                end
                S_WNEXT: state_reg <= S_WREAD;
                S_WREAD: begin
                    if (rd_order == NIL) begin
                        state_reg <= S_OUT;
                    end else begin
                        cur_reg <= rd_order;
                        cursor_reg[tsel] <= rd_order;
                        state_reg <= S_WKEY;
                        func_reg <= FUNC_FIRST;
                    end
                end
                S_WKEY: begin
                    if (func_reg == FUNC_FIRST) begin
                        func_reg <= FUNC_SEARCH;
                    end else begin
                        hit_reg <= 1'b1;
                        sk_reg <= rd_key;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
